### rtl/wfts_pkg.sv
// wfts_pkg.sv: shared types and constants for the wall follow turn sequencer
`timescale 1ns / 1ps

package wfts_pkg;

    // sequencer modes
    typedef enum logic [2:0] {
        MODE_STOP         = 3'd0,
        MODE_FOLLOW_RIGHT = 3'd1,
        MODE_LEFT_TURN    = 3'd2,
        MODE_RIGHT_TURN   = 3'd3,
        MODE_FOLLOW_LEFT  = 3'd4
    } mode_t;

    // scenario codes from the maze classifier
    localparam logic [3:0] SC_STRAIGHT = 4'd8;
    localparam logic [3:0] SC_LEFT     = 4'd9;
    localparam logic [3:0] SC_RIGHT    = 4'd10;
    localparam logic [3:0] SC_TEE      = 4'd11;
    localparam logic [3:0] SC_BLOCKED  = 4'd15;

    // configuration register indexes
    localparam logic [2:0] CFG_KP           = 3'd0;
    localparam logic [2:0] CFG_SETPOINT     = 3'd1;
    localparam logic [2:0] CFG_BASE_DUTY    = 3'd2;
    localparam logic [2:0] CFG_DUTY_MIN     = 3'd3;
    localparam logic [2:0] CFG_DUTY_MAX     = 3'd4;
    localparam logic [2:0] CFG_LEFT_WINDOW  = 3'd5;
    localparam logic [2:0] CFG_RIGHT_WINDOW = 3'd6;
    localparam logic [2:0] CFG_RIGHT_TICKS  = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration reset values
    localparam logic [9:0]  KP_RESET           = 10'd45;
    localparam logic [11:0] SETPOINT_RESET     = 12'd200;
    localparam logic [9:0]  BASE_DUTY_RESET    = 10'd800;
    localparam logic [9:0]  DUTY_MIN_RESET     = 10'd500;
    localparam logic [9:0]  DUTY_MAX_RESET     = 10'd1000;
    localparam logic [15:0] LEFT_WINDOW_RESET  = 16'd200;
    localparam logic [15:0] RIGHT_WINDOW_RESET = 16'd750;
    localparam logic [15:0] RIGHT_TICKS_RESET  = 16'd80;

    // fixed turn duties
    localparam logic [9:0] DUTY_INSIDE  = 10'd374;
    localparam logic [9:0] DUTY_OUTSIDE = 10'd608;
    localparam logic [9:0] DUTY_ZERO    = 10'd0;

    // last phase of the stop blink period, in ticks
    localparam logic [5:0] BLINK_LAST = 6'd49;

    // gain product and divide by 100 through a reciprocal
    // floor(p / 100) == (p * RECIP) >> SHIFT for every p below 2^22
    localparam int PROD_W       = 22;
    localparam int RECIP_W      = 23;
    localparam int QUOT_W       = 16;
    localparam int DIV100_SHIFT = 29;
    localparam logic [RECIP_W-1:0] DIV100_RECIP = 23'd5368710;

    // signed width for base duty plus or minus the adjustment
    localparam int SUM_W = 18;

    typedef struct packed {
        logic [9:0]  kp;
        logic [11:0] wall_setpoint;
        logic [9:0]  base_duty;
        logic [9:0]  duty_min;
        logic [9:0]  duty_max;
        logic [15:0] left_window_start;
        logic [15:0] right_window_start;
        logic [15:0] right_turn_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  scenario;
        logic [11:0] left_distance;
        logic [11:0] right_distance;
    } in_item_t;

    typedef struct packed {
        logic [9:0] left_duty;
        logic [9:0] right_duty;
        logic       motor_halt;
        logic       led_blue;
        logic [2:0] mode_out;
    } out_item_t;

    // per request result of the sequencer, carried down the steering pipe
    typedef struct packed {
        logic        use_follow;
        logic        err_neg;
        logic [11:0] err_mag;
        logic [9:0]  fixed_left;
        logic [9:0]  fixed_right;
        logic        motor_halt;
        logic        led_blue;
        logic [2:0]  mode_out;
    } step_t;

endpackage

### rtl/wfts_mode_seq.sv
// wfts_mode_seq.sv: five mode sequencer with tick counter, turn mark and stop blink
`timescale 1ns / 1ps

module wfts_mode_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  wfts_pkg::in_item_t item,
    input  wfts_pkg::cfg_t     cfg,
    output wfts_pkg::step_t    info
);
    import wfts_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [15:0] go_ticks_reg, go_ticks_next;
    logic [15:0] turn_mark_reg, turn_mark_next;
    logic [5:0]  stop_phase_reg, stop_phase_next;
    logic        blink_reg, blink_next;

    logic [15:0]        elapsed;
    logic               left_code;
    logic               turn_code;
    logic signed [12:0] err;

    assign elapsed   = go_ticks_reg - turn_mark_reg;
    assign left_code = (item.scenario == SC_LEFT) || (item.scenario == SC_TEE);
    assign turn_code = left_code || (item.scenario == SC_RIGHT);

    // next mode and turn mark
    always_comb
    begin
        mode_next      = mode_reg;
        turn_mark_next = turn_mark_reg;
        unique case (mode_reg)
            MODE_STOP:
            begin
                if (item.scenario != SC_BLOCKED)
                    mode_next = MODE_FOLLOW_LEFT;
            end
            MODE_LEFT_TURN:
            begin
                if (item.scenario == SC_STRAIGHT)
                    mode_next = MODE_FOLLOW_RIGHT;
            end
            MODE_RIGHT_TURN:
            begin
                if ((item.scenario == SC_STRAIGHT) || (elapsed > cfg.right_turn_ticks))
                    mode_next = MODE_FOLLOW_LEFT;
            end
            MODE_FOLLOW_LEFT:
            begin
                if (item.scenario == SC_BLOCKED)
                    mode_next = MODE_STOP;
            end
            default:
            begin
                // right turn window wins over the left turn window
                priority if ((go_ticks_reg >= cfg.right_window_start) && turn_code)
                begin
                    mode_next      = MODE_RIGHT_TURN;
                    turn_mark_next = go_ticks_reg;
                end
                else if ((go_ticks_reg < cfg.right_window_start) &&
                         (go_ticks_reg > cfg.left_window_start) && left_code)
                begin
                    mode_next = MODE_LEFT_TURN;
                end
                else
                begin
                    mode_next = mode_reg;
                end
            end
        endcase
    end

    // tick counter and stop blink
    always_comb
    begin
        go_ticks_next   = go_ticks_reg;
        stop_phase_next = stop_phase_reg;
        blink_next      = blink_reg;
        if (mode_reg == MODE_STOP)
        begin
            if (stop_phase_reg == 6'd0)
                blink_next = ~blink_reg;
            stop_phase_next = (stop_phase_reg == BLINK_LAST) ? 6'd0 : stop_phase_reg + 6'd1;
        end
        else
        begin
            go_ticks_next = go_ticks_reg + 16'd1;
        end
    end

    // steering error and fixed duties from the mode at tick start; halt, blink and mode out from the next state
    always_comb
    begin
        if (mode_reg == MODE_FOLLOW_LEFT)
            err = signed'({1'b0, item.left_distance}) - signed'({1'b0, cfg.wall_setpoint});
        else
            err = signed'({1'b0, cfg.wall_setpoint}) - signed'({1'b0, item.right_distance});

        info.err_neg     = err[12];
        info.err_mag     = err[12] ? 12'(-err) : err[11:0];
        info.use_follow  = 1'b0;
        info.fixed_left  = DUTY_ZERO;
        info.fixed_right = DUTY_ZERO;
        unique case (mode_reg)
            MODE_STOP:
            begin
                info.fixed_left  = DUTY_ZERO;
                info.fixed_right = DUTY_ZERO;
            end
            MODE_LEFT_TURN:
            begin
                info.fixed_left  = DUTY_INSIDE;
                info.fixed_right = DUTY_OUTSIDE;
            end
            MODE_RIGHT_TURN:
            begin
                info.fixed_left  = DUTY_OUTSIDE;
                info.fixed_right = DUTY_INSIDE;
            end
            default:
            begin
                info.use_follow = 1'b1;
            end
        endcase
        info.motor_halt = (mode_next == MODE_STOP);
        info.led_blue   = blink_next;
        info.mode_out   = mode_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_FOLLOW_RIGHT;
            go_ticks_reg   <= 16'd0;
            turn_mark_reg  <= 16'd0;
            stop_phase_reg <= 6'd0;
            blink_reg      <= 1'b0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            go_ticks_reg   <= go_ticks_next;
            turn_mark_reg  <= turn_mark_next;
            stop_phase_reg <= stop_phase_next;
            blink_reg      <= blink_next;
        end
    end

    // stop phase never leaves the blink period
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        stop_phase_reg <= BLINK_LAST)
        else $error("stop phase out of range");

    // the tick counter holds while stopped
    a_ticks_hold_in_stop: assert property (@(posedge clk) disable iff (!rst_n)
        step && (mode_reg == MODE_STOP) |=> $stable(go_ticks_reg))
        else $error("tick counter moved in stop");

    // blink colour only changes on a stop request with phase zero
    a_blink_only_in_stop: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && (mode_reg == MODE_STOP) && (stop_phase_reg == 6'd0))
        |=> $stable(blink_reg))
        else $error("blink colour toggled outside stop");

endmodule

### rtl/wall_follow_turn_sequencer_core.sv
// wall_follow_turn_sequencer_core.sv: top level, config registers and steering pipeline
//
//   channel   direction  payload      handshake
//   in        input      in_item_t    in_valid / in_stall
//   out       output     out_item_t   out_valid / out_stall
//   cfg       input      cfg_data     cfg_we, cfg_index
//
// one request per cycle while in_stall is low; a result passes through the stage one register,
// the stage two register and then the output register
// stage one is the gain multiply, stage two the divide by 100 through a reciprocal
// multiply, stage three the base duty offset and clamp into the output register
// reset loads the default config, follow right mode and clears all counters
// out_stall holds the output register and backs up into in_stall once all stages are full
`timescale 1ns / 1ps

module wall_follow_turn_sequencer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  wfts_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output wfts_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [wfts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wfts_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wfts_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic  in_acc;
    logic  out_can, s2_can, s1_can;
    step_t seq_info;

    logic [PROD_W-1:0]         prod;
    logic [PROD_W+RECIP_W-1:0] recip_prod;

    logic                 s1_valid_reg, s1_valid_next;
    logic [PROD_W-1:0]    s1_prod_reg;
    step_t                s1_info_reg;
    logic                 s2_valid_reg, s2_valid_next;
    logic [QUOT_W-1:0]    s2_quot_reg;
    step_t                s2_info_reg;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    logic signed [SUM_W-1:0] base_s, quot_s, lo_s, hi_s;

    // clamp to max first, then to min
    function automatic logic [9:0] clamp_duty(input logic signed [SUM_W-1:0] x,
                                              input logic [9:0] lo,
                                              input logic [9:0] hi);
        logic signed [SUM_W-1:0] t;
        t = x;
        if (t > signed'(SUM_W'(hi)))
            t = signed'(SUM_W'(hi));
        if (t < signed'(SUM_W'(lo)))
            t = signed'(SUM_W'(lo));
        return t[9:0];
    endfunction

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KP:           cfg_next.kp                 = cfg_data[9:0];
                CFG_SETPOINT:     cfg_next.wall_setpoint      = cfg_data[11:0];
                CFG_BASE_DUTY:    cfg_next.base_duty          = cfg_data[9:0];
                CFG_DUTY_MIN:     cfg_next.duty_min           = cfg_data[9:0];
                CFG_DUTY_MAX:     cfg_next.duty_max           = cfg_data[9:0];
                CFG_LEFT_WINDOW:  cfg_next.left_window_start  = cfg_data;
                CFG_RIGHT_WINDOW: cfg_next.right_window_start = cfg_data;
                CFG_RIGHT_TICKS:  cfg_next.right_turn_ticks   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp                 <= KP_RESET;
            cfg_reg.wall_setpoint      <= SETPOINT_RESET;
            cfg_reg.base_duty          <= BASE_DUTY_RESET;
            cfg_reg.duty_min           <= DUTY_MIN_RESET;
            cfg_reg.duty_max           <= DUTY_MAX_RESET;
            cfg_reg.left_window_start  <= LEFT_WINDOW_RESET;
            cfg_reg.right_window_start <= RIGHT_WINDOW_RESET;
            cfg_reg.right_turn_ticks   <= RIGHT_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline flow control
    assign out_can  = !out_valid_reg || !out_stall;
    assign s2_can   = !s2_valid_reg || out_can;
    assign s1_can   = !s1_valid_reg || s2_can;
    assign in_stall = !s1_can;
    assign in_acc   = in_valid && s1_can;

    // mode sequencer, steps once per accepted request
    wfts_mode_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_acc),
        .item  (in_data),
        .cfg   (cfg_reg),
        .info  (seq_info)
    );

    // stage one: gain times error magnitude
    assign prod = PROD_W'(cfg_reg.kp) * PROD_W'(seq_info.err_mag);

    // stage two: divide by 100
    assign recip_prod = (PROD_W+RECIP_W)'(s1_prod_reg) * (PROD_W+RECIP_W)'(DIV100_RECIP);

    // stage three: offset from base duty and clamp
    always_comb
    begin
        base_s = signed'(SUM_W'(cfg_reg.base_duty));
        quot_s = signed'(SUM_W'(s2_quot_reg));
        lo_s   = base_s - quot_s;
        hi_s   = base_s + quot_s;

        out_data_next.motor_halt = s2_info_reg.motor_halt;
        out_data_next.led_blue   = s2_info_reg.led_blue;
        out_data_next.mode_out   = s2_info_reg.mode_out;
        if (s2_info_reg.use_follow)
        begin
            // left gets base minus the signed adjustment, right base plus it
            out_data_next.left_duty  = clamp_duty(s2_info_reg.err_neg ? hi_s : lo_s,
                                                  cfg_reg.duty_min, cfg_reg.duty_max);
            out_data_next.right_duty = clamp_duty(s2_info_reg.err_neg ? lo_s : hi_s,
                                                  cfg_reg.duty_min, cfg_reg.duty_max);
        end
        else
        begin
            out_data_next.left_duty  = s2_info_reg.fixed_left;
            out_data_next.right_duty = s2_info_reg.fixed_right;
        end
    end

    // valid bits
    always_comb
    begin
        s1_valid_next  = s1_can  ? in_valid      : s1_valid_reg;
        s2_valid_next  = s2_can  ? s1_valid_reg  : s2_valid_reg;
        out_valid_next = out_can ? s2_valid_reg  : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_can)
        begin
            s1_prod_reg <= prod;
            s1_info_reg <= seq_info;
        end
        if (s2_can)
        begin
            s2_quot_reg <= recip_prod[DIV100_SHIFT +: QUOT_W];
            s2_info_reg <= s1_info_reg;
        end
        if (out_can)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // backpressure reaches the input only when stage one holds a request
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with stage one empty");

    // halt flag agrees with the reported mode
    a_halt_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.motor_halt ==
                           (out_data_reg.mode_out == MODE_STOP)))
        else $error("halt flag disagrees with mode");

    // a full pipe with a stalled output keeps every stage
    a_full_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall && s2_valid_reg && s1_valid_reg
        |=> out_valid_reg && s2_valid_reg && s1_valid_reg)
        else $error("request lost while stalled");

endmodule
